// ===== src/bvs_pkg.sv =====
// bvs_pkg: shared constants, phase codes, register indexes and types of the
// breath valve sequencer. No dependencies.
`default_nettype none

package bvs_pkg;

  // Field and register widths
  localparam int POT_W    = 10;
  localparam int HOLD_W   = 4;
  localparam int CMD_W    = 2;
  localparam int UNIT_W   = 12;
  localparam int PERIOD_W = 8;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  // Converter and timer constants
  localparam int ADC_MAX    = 1023;
  localparam int TIMER_BITS = 12;
  localparam int CMP_W      = ((TIMER_BITS > UNIT_W) ? TIMER_BITS : UNIT_W) + 1;
  localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'((1 << TIMER_BITS) - 1);
  localparam logic [HOLD_W-1:0] HOLD_CAP  = HOLD_W'(10);
  localparam logic [HOLD_W-1:0] COUNT_CAP = HOLD_W'(15);
  localparam logic [HOLD_W-1:0] SHORT_TARGET = HOLD_W'(2);
  localparam int POT_STEPS  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_UNIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_UNIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_UNIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [UNIT_W-1:0]   HOLD_UNIT_RST   = 12'd1000;
  localparam logic [UNIT_W-1:0]   SETTLE_UNIT_RST = 12'd250;
  localparam logic [UNIT_W-1:0]   GAP_UNIT_RST    = 12'd100;
  localparam logic [PERIOD_W-1:0] SAMPLE_PER_RST  = 8'd10;

  // Sequencer phases
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_SETTLE_A = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRESS    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SETTLE_B = 3'd2;
  localparam logic [PHASE_W-1:0] PH_GAP_A    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELIEF   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_GAP_B    = 3'd5;

  // Motor command codes (CMD_W bits)
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd0;

  // Run and hold status after this tick's button and sample update
  typedef struct packed {
    logic              run;
    logic [HOLD_W-1:0] press_hold;
    logic [HOLD_W-1:0] relief_hold;
  } bvs_status_t;

  // Valve drive and motor command for one tick
  typedef struct packed {
    logic             press_valve;
    logic             relief_valve;
    logic             cmd_valid;
    logic [CMD_W-1:0] cmd_byte;
  } bvs_drive_t;

  // pot*8/ADC_MAX + 2, capped: count the thresholds k*ADC_MAX/8 reached
  function automatic logic [HOLD_W-1:0] pot_to_units(input logic [POT_W-1:0] pot);
    logic [HOLD_W-1:0] q;
    logic [POT_W+3:0]  scaled;
    q      = HOLD_W'(2);
    scaled = {pot, 3'b000};
    for (int k = 1; k <= POT_STEPS; k++) begin
      if (32'(scaled) >= 32'(k * ADC_MAX)) begin
        q = q + HOLD_W'(1);
      end
    end
    if (q > HOLD_CAP) begin
      q = HOLD_CAP;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== src/breath_valve_sequencer.sv =====
// breath_valve_sequencer: top level with input register, configuration
// registers, result register; uses bvs_pkg, bvs_sampler and bvs_phase_seq.
//
//   channel  | ports                                     | handshake
//   ---------+-------------------------------------------+------------------
//   input    | in_button_level, in_press_pot, in_relief_pot | in_valid/in_ready
//   result   | out_press_valve .. out_running (7 fields) | out_valid/out_ready
//   config   | cfg_index, cfg_wdata                      | cfg_we, no wait
//
// One beat per clock cycle sustained while out_ready is high; an accepted beat
// passes from the input register into the result register when not stalled.
// The tick's update of all sequencer state happens in the one cycle a beat
// moves from the input register into the result register.
// Reset (rst_n low, synchronous) clears both valid flags and all sequencer state and
// loads the configuration reset values.
// A stalled result holds in its register; the input register still takes a
// new beat whenever the result register is free or is being drained.
`default_nettype none

module breath_valve_sequencer
  import bvs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_button_level,
  input  wire logic [POT_W-1:0]     in_press_pot,
  input  wire logic [POT_W-1:0]     in_relief_pot,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_press_valve,
  output logic                      out_relief_valve,
  output logic                      out_cmd_valid,
  output logic [CMD_W-1:0]          out_cmd_byte,
  output logic [HOLD_W-1:0]         out_press_seconds,
  output logic [HOLD_W-1:0]         out_relief_seconds,
  output logic                      out_running,
  // configuration port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [UNIT_W-1:0]   hold_unit_r, settle_unit_r, gap_unit_r;
  logic [PERIOD_W-1:0] sample_per_r;

  // input register
  logic             in_vld_r;
  logic             btn_r;
  logic [POT_W-1:0] ppot_r, rpot_r;

  // result register
  logic              out_vld_r;
  bvs_drive_t        drive_r;
  bvs_status_t       status_r;

  logic        advance;
  bvs_status_t status_nxt;
  bvs_drive_t  drive_nxt;

  // advance the input beat whenever the result register is free or draining
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_unit_r   <= HOLD_UNIT_RST;
      settle_unit_r <= SETTLE_UNIT_RST;
      gap_unit_r    <= GAP_UNIT_RST;
      sample_per_r  <= SAMPLE_PER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLD_UNIT:   hold_unit_r   <= cfg_wdata[UNIT_W-1:0];
        REG_SETTLE_UNIT: settle_unit_r <= cfg_wdata[UNIT_W-1:0];
        REG_GAP_UNIT:    gap_unit_r    <= cfg_wdata[UNIT_W-1:0];
        REG_SAMPLE_PER:  sample_per_r  <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: control reset, payload loads on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      btn_r  <= in_button_level;
      ppot_r <= in_press_pot;
      rpot_r <= in_relief_pot;
    end
  end

  bvs_sampler u_sampler (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .button_level  (btn_r),
    .press_pot     (ppot_r),
    .relief_pot    (rpot_r),
    .sample_period (sample_per_r),
    .status_nxt    (status_nxt)
  );

  bvs_phase_seq u_phase_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .status      (status_nxt),
    .hold_unit   (hold_unit_r),
    .settle_unit (settle_unit_r),
    .gap_unit    (gap_unit_r),
    .drive_nxt   (drive_nxt)
  );

  // result register: hold while stalled, drop the flag once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_r  <= drive_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_press_valve    = drive_r.press_valve;
  assign out_relief_valve   = drive_r.relief_valve;
  assign out_cmd_valid      = drive_r.cmd_valid;
  assign out_cmd_byte       = drive_r.cmd_byte;
  assign out_press_seconds  = status_r.press_hold;
  assign out_relief_seconds = status_r.relief_hold;
  assign out_running        = status_r.run;

endmodule

`default_nettype wire

// ===== src/bvs_sampler.sv =====
// bvs_sampler: start/stop toggle and potentiometer sampling of hold times.
// Depends on bvs_pkg.
`default_nettype none

module bvs_sampler
  import bvs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic                button_level,
  input  wire logic [POT_W-1:0]    press_pot,
  input  wire logic [POT_W-1:0]    relief_pot,
  input  wire logic [PERIOD_W-1:0] sample_period,
  output bvs_status_t              status_nxt
);

  logic                run_r, run_nxt;
  logic                latch_r, latch_nxt;
  logic [PERIOD_W-1:0] stimer_r, stimer_nxt;
  logic [HOLD_W-1:0]   phold_r, phold_nxt;
  logic [HOLD_W-1:0]   rhold_r, rhold_nxt;
  logic [POT_W-1:0]    plast_r, plast_nxt;
  logic [POT_W-1:0]    rlast_r, rlast_nxt;
  logic [PERIOD_W-1:0] period;

  always_comb begin
    run_nxt    = run_r;
    latch_nxt  = latch_r;
    stimer_nxt = stimer_r;
    phold_nxt  = phold_r;
    rhold_nxt  = rhold_r;
    plast_nxt  = plast_r;
    rlast_nxt  = rlast_r;
    period     = (sample_period == '0) ? PERIOD_W'(1) : sample_period;

    // toggle once per press, hold the latch until release
    if (!button_level && !latch_r) begin
      run_nxt   = ~run_r;
      latch_nxt = 1'b1;
    end else if (button_level && latch_r) begin
      latch_nxt = 1'b0;
    end

    if (stimer_r == '0) begin
      if (press_pot != plast_r) begin
        phold_nxt = pot_to_units(press_pot);
      end
      if (relief_pot != rlast_r) begin
        rhold_nxt = pot_to_units(relief_pot);
      end
      plast_nxt  = press_pot;
      rlast_nxt  = relief_pot;
      stimer_nxt = period - PERIOD_W'(1);
    end else begin
      stimer_nxt = stimer_r - PERIOD_W'(1);
    end
  end

  assign status_nxt = '{run: run_nxt, press_hold: phold_nxt, relief_hold: rhold_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      latch_r  <= 1'b0;
      stimer_r <= '0;
      phold_r  <= '0;
      rhold_r  <= '0;
      plast_r  <= '0;
      rlast_r  <= '0;
    end else if (step) begin
      run_r    <= run_nxt;
      latch_r  <= latch_nxt;
      stimer_r <= stimer_nxt;
      phold_r  <= phold_nxt;
      rhold_r  <= rhold_nxt;
      plast_r  <= plast_nxt;
      rlast_r  <= rlast_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/bvs_phase_seq.sv =====
// bvs_phase_seq: six-phase valve sequencer with unit timers and motor commands.
// Depends on bvs_pkg.
`default_nettype none

module bvs_phase_seq
  import bvs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire bvs_status_t       status,
  input  wire logic [UNIT_W-1:0] hold_unit,
  input  wire logic [UNIT_W-1:0] settle_unit,
  input  wire logic [UNIT_W-1:0] gap_unit,
  output bvs_drive_t             drive_nxt
);

  logic [PHASE_W-1:0]    phase_r, phase_nxt;
  logic [HOLD_W-1:0]     count_r, count_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic                  pv_r, pv_nxt;
  logic                  rv_r, rv_nxt;
  logic                  cmd_valid;
  logic [CMD_W-1:0]      cmd_byte;
  logic [HOLD_W-1:0]     target;
  logic [UNIT_W-1:0]     unit_sel;
  logic [CMP_W-1:0]      unit_len;
  logic [CMP_W-1:0]      tick_nxt;
  logic                  active;

  always_comb begin
    case (phase_r)
      PH_SETTLE_A: begin target = SHORT_TARGET;       unit_sel = settle_unit; end
      PH_PRESS:    begin target = status.press_hold;  unit_sel = hold_unit;   end
      PH_SETTLE_B: begin target = SHORT_TARGET;       unit_sel = settle_unit; end
      PH_GAP_A:    begin target = SHORT_TARGET;       unit_sel = gap_unit;    end
      PH_RELIEF:   begin target = status.relief_hold; unit_sel = hold_unit;   end
      PH_GAP_B:    begin target = SHORT_TARGET;       unit_sel = gap_unit;    end
      default:     begin target = '0;                 unit_sel = UNIT_W'(1);  end
    endcase
    unit_len = (unit_sel == '0) ? CMP_W'(1) : CMP_W'(unit_sel);
    tick_nxt = CMP_W'(timer_r) + CMP_W'(1);
    active   = status.run && (status.press_hold != '0) && (status.relief_hold != '0);

    phase_nxt = phase_r;
    count_nxt = count_r;
    timer_nxt = timer_r;
    pv_nxt    = pv_r;
    rv_nxt    = rv_r;
    cmd_valid = 1'b0;
    cmd_byte  = CMD_STOP;

    if (active) begin
      if (phase_r == PH_SETTLE_A) begin
        pv_nxt = 1'b1;
      end
      if (phase_r > PH_GAP_B) begin
        // unknown phase: restart the cycle without a command
        phase_nxt = PH_SETTLE_A;
        count_nxt = '0;
        timer_nxt = '0;
      end else if (count_r >= target) begin
        count_nxt = '0;
        timer_nxt = '0;
        case (phase_r)
          PH_SETTLE_A: begin
            cmd_valid = 1'b1;
            cmd_byte  = CMD_START;
            phase_nxt = PH_PRESS;
          end
          PH_PRESS: begin
            cmd_valid = 1'b1;
            cmd_byte  = CMD_STOP;
            phase_nxt = PH_SETTLE_B;
          end
          PH_SETTLE_B: begin
            pv_nxt    = 1'b0;
            phase_nxt = PH_GAP_A;
          end
          PH_GAP_A: begin
            rv_nxt    = 1'b1;
            phase_nxt = PH_RELIEF;
          end
          PH_RELIEF: begin
            rv_nxt    = 1'b0;
            phase_nxt = PH_GAP_B;
          end
          default: begin
            phase_nxt = PH_SETTLE_A;
          end
        endcase
      end else if (tick_nxt >= unit_len || tick_nxt >= TIMER_MAX) begin
        timer_nxt = '0;
        if (count_r < COUNT_CAP) begin
          count_nxt = count_r + HOLD_W'(1);
        end
      end else begin
        timer_nxt = tick_nxt[TIMER_BITS-1:0];
      end
    end
  end

  assign drive_nxt = '{press_valve: pv_nxt, relief_valve: rv_nxt,
                       cmd_valid: cmd_valid, cmd_byte: cmd_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETTLE_A;
      count_r <= '0;
      timer_r <= '0;
      pv_r    <= 1'b0;
      rv_r    <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      timer_r <= timer_nxt;
      pv_r    <= pv_nxt;
      rv_r    <= rv_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/bvs_checker.sv =====
// bvs_checker: port-level assertions on the breath valve sequencer, bound to
// the top level. Depends on bvs_pkg.
`default_nettype none

module bvs_checker
  import bvs_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 out_press_valve,
  input wire logic                 out_relief_valve,
  input wire logic                 out_cmd_valid,
  input wire logic [CMD_W-1:0]     out_cmd_byte,
  input wire logic [HOLD_W-1:0]    out_press_seconds,
  input wire logic [HOLD_W-1:0]    out_relief_seconds,
  input wire logic                 out_running
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd_byte)
      && $stable(out_press_valve) && $stable(out_relief_valve))
    else $error("result beat changed while stalled");

  // motor commands only go out while running, with press open and relief shut
  a_cmd_valves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_valid |-> out_running && out_press_valve && !out_relief_valve)
    else $error("motor command outside the pressurising phases");

  // no byte without a command
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cmd_valid |-> out_cmd_byte == CMD_STOP)
    else $error("command byte set without a command");

  // hold times stay within the converter range: at most HOLD_CAP and never one
  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_press_seconds <= HOLD_CAP && out_relief_seconds <= HOLD_CAP
      && out_press_seconds != HOLD_W'(1) && out_relief_seconds != HOLD_W'(1))
    else $error("hold time out of range");

endmodule

bind breath_valve_sequencer bvs_checker u_bvs_checker (.*);

`default_nettype wire
